// File: rtl/volume_scale_peak_level_meter_unit_defines.svh
// assertion macros shared by the rtl files
`ifndef VOLUME_SCALE_PEAK_LEVEL_METER_UNIT_DEFINES_SVH
`define VOLUME_SCALE_PEAK_LEVEL_METER_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define VSPLM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define VSPLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define VSPLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vsplm_pkg.sv
package vsplm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int VOL_W       = 7;
  localparam int IVL_W       = 24;
  localparam int FLOOR_W     = 7;
  localparam int LEVEL_W     = 4;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int MAG_W       = 17;
  localparam int PROD_W      = 24;
  localparam int RECIP_W     = 23;
  localparam int RECIP_SH    = 29;
  localparam int RPROD_W     = PROD_W + RECIP_W;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int THR_W       = 15;
  localparam int THR_IDX_W   = 6;
  localparam int LEVEL_STEPS = 10;
  localparam int BAND_DB     = 4;
  localparam int LAST_THR    = 40;

  // ceil(2^29 / 100): exact floor(x / 100) for every product magnitude here
  localparam logic [RECIP_W-1:0] RECIP_K = 23'd5368710;

  localparam logic [MAG_W-1:0] POS_LIMIT = 17'd32767;
  localparam logic [MAG_W-1:0] NEG_LIMIT = 17'd32768;

  localparam logic [VOL_W-1:0]          VOLUME_RST   = 7'd100;
  localparam logic                      AMP_RST      = 1'b0;
  localparam logic [IVL_W-1:0]          INTERVAL_RST = 24'd100000;
  localparam logic signed [FLOOR_W-1:0] FLOOR_RST    = -7'sd40;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME   = 2'd0,
    REG_AMP      = 2'd1,
    REG_INTERVAL = 2'd2,
    REG_FLOOR    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [VOL_W-1:0]          volume_percent;
    logic                      amp_mode;
    logic [IVL_W-1:0]          meter_interval_ticks;
    logic signed [FLOOR_W-1:0] level_floor_db;
  } cfg_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic                       chunk_end;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [MAG_W-1:0]           mag;
  } qent_t;

  // smallest peak whose rounded dB is at least -idx
  function automatic logic [THR_W-1:0] thr_at(input logic [THR_IDX_W-1:0] idx);
    logic [THR_W-1:0] t;
    unique case (idx)
      6'd0:  t = 15'd30935;
      6'd1:  t = 15'd27571;
      6'd2:  t = 15'd24573;
      6'd3:  t = 15'd21901;
      6'd4:  t = 15'd19519;
      6'd5:  t = 15'd17397;
      6'd6:  t = 15'd15505;
      6'd7:  t = 15'd13819;
      6'd8:  t = 15'd12316;
      6'd9:  t = 15'd10977;
      6'd10: t = 15'd9783;
      6'd11: t = 15'd8719;
      6'd12: t = 15'd7771;
      6'd13: t = 15'd6926;
      6'd14: t = 15'd6173;
      6'd15: t = 15'd5502;
      6'd16: t = 15'd4903;
      6'd17: t = 15'd4370;
      6'd18: t = 15'd3895;
      6'd19: t = 15'd3471;
      6'd20: t = 15'd3094;
      6'd21: t = 15'd2758;
      6'd22: t = 15'd2458;
      6'd23: t = 15'd2191;
      6'd24: t = 15'd1952;
      6'd25: t = 15'd1740;
      6'd26: t = 15'd1551;
      6'd27: t = 15'd1382;
      6'd28: t = 15'd1232;
      6'd29: t = 15'd1098;
      6'd30: t = 15'd979;
      6'd31: t = 15'd872;
      6'd32: t = 15'd778;
      6'd33: t = 15'd693;
      6'd34: t = 15'd618;
      6'd35: t = 15'd551;
      6'd36: t = 15'd491;
      6'd37: t = 15'd437;
      6'd38: t = 15'd390;
      6'd39: t = 15'd348;
      6'd40: t = 15'd310;
      default: t = 15'd310;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/vsplm_in_if.sv
interface vsplm_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    opcode;
  logic signed [vsplm_pkg::SAMPLE_W-1:0]   sample_in;
  logic                                    chunk_end;

  modport source (output valid, output opcode, output sample_in, output chunk_end,
                  input ready);
  modport sink (input valid, input opcode, input sample_in, input chunk_end,
                output ready);
endinterface

// File: rtl/vsplm_out_if.sv
interface vsplm_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [vsplm_pkg::SAMPLE_W-1:0]   sample_out;
  logic                                    level_valid;
  logic [vsplm_pkg::LEVEL_W-1:0]           level;

  modport source (output valid, output sample_out, output level_valid, output level,
                  input ready);
  modport sink (input valid, input sample_out, input level_valid, input level,
                output ready);
endinterface

// File: rtl/vsplm_front.sv
module vsplm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  vsplm_pkg::cfg_t     cfg,
  vsplm_in_if.sink            in_chan,
  output logic                push,
  output vsplm_pkg::qent_t    push_data,
  input  logic                q_full
);

  logic                                  s1_v_r;
  logic                                  s1_op_r;
  logic                                  s1_ce_r;
  logic                                  s1_neg_r;
  logic signed [vsplm_pkg::SAMPLE_W-1:0] s1_raw_r;
  logic [vsplm_pkg::PROD_W-1:0]          s1_prod_r;

  logic                                  s2_v_r;
  logic                                  s2_op_r;
  logic                                  s2_ce_r;
  logic                                  s2_neg_r;
  logic signed [vsplm_pkg::SAMPLE_W-1:0] s2_raw_r;
  logic [vsplm_pkg::SAMPLE_W-1:0]        s2_q_r;

  logic                                  s1_adv;
  logic                                  s2_adv;
  logic                                  in_neg;
  logic [vsplm_pkg::MAG_W-1:0]           in_abs;
  logic [vsplm_pkg::PROD_W-1:0]          prod_nxt;
  logic [vsplm_pkg::RPROD_W-1:0]         rprod;
  logic [vsplm_pkg::SAMPLE_W-1:0]        q_nxt;
  logic [vsplm_pkg::MAG_W-1:0]           q_ext;
  logic [vsplm_pkg::MAG_W-1:0]           lim;
  logic [vsplm_pkg::MAG_W-1:0]           sat_mag;
  logic [vsplm_pkg::MAG_W-1:0]           scaled;

  assign s2_adv        = !s2_v_r || !q_full;
  assign push          = s2_v_r && !q_full;
  assign s1_adv        = !s1_v_r || s2_adv;
  assign in_chan.ready = s1_adv;

  // stage 1: |sample| * volume
  assign in_neg   = in_chan.sample_in[vsplm_pkg::SAMPLE_W-1];
  assign in_abs   = in_neg ? (~{in_chan.sample_in[vsplm_pkg::SAMPLE_W-1], in_chan.sample_in}
                              + vsplm_pkg::MAG_W'(1))
                           : {1'b0, in_chan.sample_in};
  assign prod_nxt = vsplm_pkg::PROD_W'(in_abs) * vsplm_pkg::PROD_W'(cfg.volume_percent);

  // stage 2: divide by 100 through the reciprocal
  assign rprod = vsplm_pkg::RPROD_W'(s1_prod_r) * vsplm_pkg::RPROD_W'(vsplm_pkg::RECIP_K);
  assign q_nxt = rprod[vsplm_pkg::RECIP_SH +: vsplm_pkg::SAMPLE_W];

  // saturate to the signed 16 bit range on the way into the queue
  assign q_ext   = {1'b0, s2_q_r};
  assign lim     = s2_neg_r ? vsplm_pkg::NEG_LIMIT : vsplm_pkg::POS_LIMIT;
  assign sat_mag = (q_ext > lim) ? lim : q_ext;
  assign scaled  = s2_neg_r ? (~sat_mag + vsplm_pkg::MAG_W'(1)) : sat_mag;

  always_comb begin
    push_data.opcode     = vsplm_pkg::opcode_t'(s2_op_r);
    push_data.chunk_end  = s2_ce_r;
    push_data.sample_out = cfg.amp_mode ? s2_raw_r
                                        : $signed(scaled[vsplm_pkg::SAMPLE_W-1:0]);
    push_data.mag        = sat_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_chan.valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_chan.valid) begin
      s1_op_r   <= in_chan.opcode;
      s1_ce_r   <= in_chan.chunk_end;
      s1_neg_r  <= in_neg;
      s1_raw_r  <= in_chan.sample_in;
      s1_prod_r <= prod_nxt;
    end
    if (s2_adv && s1_v_r) begin
      s2_op_r  <= s1_op_r;
      s2_ce_r  <= s1_ce_r;
      s2_neg_r <= s1_neg_r;
      s2_raw_r <= s1_raw_r;
      s2_q_r   <= q_nxt;
    end
  end

endmodule

// File: rtl/vsplm_fifo.sv
`include "volume_scale_peak_level_meter_unit_defines.svh"

module vsplm_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vsplm_pkg::qent_t    push_data,
  output logic                full,
  input  logic                pop,
  output vsplm_pkg::qent_t    pop_data,
  output logic                empty
);

  vsplm_pkg::qent_t                mem_r [vsplm_pkg::QDEPTH];
  logic [vsplm_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [vsplm_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [vsplm_pkg::QCNT_W-1:0]    cnt_r;
  logic [vsplm_pkg::QCNT_W-1:0]    cnt_nxt;

  assign full     = (cnt_r == vsplm_pkg::QCNT_W'(vsplm_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (push && !pop) begin
      cnt_nxt = cnt_r + vsplm_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - vsplm_pkg::QCNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + vsplm_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + vsplm_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `VSPLM_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= vsplm_pkg::QCNT_W'(vsplm_pkg::QDEPTH), "queue count past depth")
  `VSPLM_ASSERT_NEXT(a_cnt_grow, push && !pop, cnt_r == $past(cnt_r) + vsplm_pkg::QCNT_W'(1), "queue count missed a push")

endmodule

// File: rtl/vsplm_back.sv
`include "volume_scale_peak_level_meter_unit_defines.svh"

module vsplm_back #(
  parameter int TIMER_WIDTH = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vsplm_pkg::cfg_t     cfg,
  input  logic                q_empty,
  input  vsplm_pkg::qent_t    q_data,
  output logic                pop,
  vsplm_out_if.source         out_chan
);

  localparam int CMP_W = (TIMER_WIDTH > vsplm_pkg::IVL_W) ? TIMER_WIDTH : vsplm_pkg::IVL_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

  logic [vsplm_pkg::MAG_W-1:0]           peak_r, peak_nxt;
  logic                                  run_r, run_nxt;
  logic [TIMER_WIDTH-1:0]                el_r, el_nxt;

  logic                                  a_v_r;
  logic signed [vsplm_pkg::SAMPLE_W-1:0] a_sample_r;
  logic                                  a_rep_r;
  logic [vsplm_pkg::MAG_W-1:0]           a_peak_r;

  logic                                  o_v_r;
  logic signed [vsplm_pkg::SAMPLE_W-1:0] o_sample_r;
  logic                                  o_lv_r;
  logic [vsplm_pkg::LEVEL_W-1:0]         o_level_r;

  logic                                  o_adv;
  logic                                  a_ready;
  logic                                  is_sample;
  logic                                  rep;
  logic [vsplm_pkg::MAG_W-1:0]           new_peak;
  logic                                  floor_pos;
  logic [vsplm_pkg::FLOOR_W-1:0]         neg_floor;
  logic [vsplm_pkg::THR_IDX_W-1:0]       gate_idx;
  logic                                  gate;
  logic [vsplm_pkg::LEVEL_W-1:0]         band_cnt;
  logic [vsplm_pkg::LEVEL_W-1:0]         level_nxt;

  assign o_adv     = !o_v_r || out_chan.ready;
  assign a_ready   = !a_v_r || o_adv;
  assign pop       = !q_empty && a_ready;
  assign is_sample = (q_data.opcode == vsplm_pkg::OP_SAMPLE);
  assign new_peak  = (q_data.mag > peak_r) ? q_data.mag : peak_r;

  // chunk peak and meter timer, in item order
  always_comb begin
    peak_nxt = peak_r;
    run_nxt  = run_r;
    el_nxt   = el_r;
    rep      = 1'b0;
    if (pop) begin
      if (!is_sample) begin
        if (run_r && el_r != TMAX) begin
          el_nxt = el_r + TIMER_WIDTH'(1);
        end
      end else if (q_data.chunk_end) begin
        peak_nxt = '0;
        if (!run_r) begin
          run_nxt = 1'b1;
          el_nxt  = '0;
        end else if (CMP_W'(el_r) > CMP_W'(cfg.meter_interval_ticks)) begin
          rep     = 1'b1;
          run_nxt = 1'b0;
          el_nxt  = '0;
        end
      end else begin
        peak_nxt = new_peak;
      end
    end
  end

  // level: one count per 4 dB band, gated by the floor and the lowest band
  always_comb begin
    floor_pos = !cfg.level_floor_db[vsplm_pkg::FLOOR_W-1] && (cfg.level_floor_db != '0);
    neg_floor = vsplm_pkg::FLOOR_W'(0) - cfg.level_floor_db;
    gate_idx  = (neg_floor > vsplm_pkg::FLOOR_W'(vsplm_pkg::LAST_THR))
              ? vsplm_pkg::THR_IDX_W'(vsplm_pkg::LAST_THR)
              : neg_floor[vsplm_pkg::THR_IDX_W-1:0];
    gate      = !floor_pos &&
                (a_peak_r >= vsplm_pkg::MAG_W'(vsplm_pkg::thr_at(gate_idx)));
    band_cnt  = '0;
    for (int b = 1; b <= vsplm_pkg::LEVEL_STEPS; b++) begin
      band_cnt = band_cnt + vsplm_pkg::LEVEL_W'(
        a_peak_r >= vsplm_pkg::MAG_W'(
          vsplm_pkg::thr_at(vsplm_pkg::THR_IDX_W'(vsplm_pkg::BAND_DB * b))));
    end
    level_nxt = (a_rep_r && gate) ? band_cnt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      run_r  <= 1'b0;
      el_r   <= '0;
      a_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      peak_r <= peak_nxt;
      run_r  <= run_nxt;
      el_r   <= el_nxt;
      if (a_ready) begin
        a_v_r <= pop && is_sample;
      end
      if (o_adv) begin
        o_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_sample) begin
      a_sample_r <= q_data.sample_out;
      a_rep_r    <= rep;
      a_peak_r   <= new_peak;
    end
    if (o_adv && a_v_r) begin
      o_sample_r <= a_sample_r;
      o_lv_r     <= a_rep_r;
      o_level_r  <= level_nxt;
    end
  end

  assign out_chan.valid       = o_v_r;
  assign out_chan.sample_out  = o_sample_r;
  assign out_chan.level_valid = o_lv_r;
  assign out_chan.level       = o_level_r;

  `VSPLM_ASSERT_IMP(a_level_range, o_v_r, o_level_r <= vsplm_pkg::LEVEL_W'(vsplm_pkg::LEVEL_STEPS), "level above ten")
  `VSPLM_ASSERT_IMP(a_level_quiet, o_v_r && !o_lv_r, o_level_r == '0, "level without report")
  `VSPLM_ASSERT_NEXT(a_report_stops, rep, !run_r && el_r == '0, "timer still running after report")

endmodule

// File: rtl/volume_scale_peak_level_meter_unit.sv
// volume scaler with a chunk peak level meter
// in_chan carries requests: opcode 0 is a pcm sample (sample_in, chunk_end),
// opcode 1 is one timer tick. every sample request gives exactly one result on
// out_chan; a tick gives none. results keep request order.
// sample_out is sample_in * volume_percent / 100, truncated toward zero and
// saturated, or the raw sample when amp_mode is set. level_valid marks a chunk
// end at which the meter interval has passed; level is then 0..10.
// a result passes two multiply stages, the request queue, the meter stage and
// the output register on its way from in_chan to out_chan.
// throughput: one request per cycle unless out_chan.ready stalls the meter stage.
// a four-entry queue between the scaler and the meter lets each side stall on
// its own; when out_chan.ready is low the output register holds and in_chan.ready
// drops once the stages and the queue behind it are full.
// cfg_we writes cfg_wdata into register cfg_index; write only while idle.
// reset (rst_n low, synchronous) empties the pipeline, clears the chunk peak
// and timer, and loads volume 100, amp off, interval 100000, floor -40 dB.
module volume_scale_peak_level_meter_unit #(
  parameter int TIMER_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  vsplm_in_if.sink                             in_chan,
  vsplm_out_if.source                          out_chan,
  input  logic                                 cfg_we,
  input  logic [vsplm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vsplm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  vsplm_pkg::cfg_t  cfg_r;
  vsplm_pkg::qent_t push_data;
  vsplm_pkg::qent_t pop_data;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.volume_percent       <= vsplm_pkg::VOLUME_RST;
      cfg_r.amp_mode             <= vsplm_pkg::AMP_RST;
      cfg_r.meter_interval_ticks <= vsplm_pkg::INTERVAL_RST;
      cfg_r.level_floor_db       <= vsplm_pkg::FLOOR_RST;
    end else if (cfg_we) begin
      unique case (vsplm_pkg::cfg_reg_t'(cfg_index))
        vsplm_pkg::REG_VOLUME: begin
          cfg_r.volume_percent <= cfg_wdata[vsplm_pkg::VOL_W-1:0];
        end
        vsplm_pkg::REG_AMP: begin
          cfg_r.amp_mode <= cfg_wdata[0];
        end
        vsplm_pkg::REG_INTERVAL: begin
          cfg_r.meter_interval_ticks <= cfg_wdata[vsplm_pkg::IVL_W-1:0];
        end
        vsplm_pkg::REG_FLOOR: begin
          cfg_r.level_floor_db <= $signed(cfg_wdata[vsplm_pkg::FLOOR_W-1:0]);
        end
      endcase
    end
  end

  vsplm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_chan   (in_chan),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  vsplm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  vsplm_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
